// ===== sv/tms_pkg.sv =====
// Package for the tagged mark stack: command, status and kind codes,
// and the packed word types of the command and result channels.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tms_pkg;

  localparam logic [2:0] CMD_PUSH_ELEM = 3'd0;
  localparam logic [2:0] CMD_PUSH_NODE = 3'd1;
  localparam logic [2:0] CMD_POP       = 3'd2;
  localparam logic [2:0] CMD_SET_TOP   = 3'd3;
  localparam logic [2:0] CMD_READ      = 3'd4;
  localparam logic [2:0] CMD_WRITE     = 3'd5;
  localparam logic [2:0] CMD_FIND      = 3'd6;
  localparam logic [2:0] CMD_QUERY     = 3'd7;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_EMPTY = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;
  localparam logic [1:0] STS_RANGE = 2'd3;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_ELEM = 2'd1;
  localparam logic [1:0] KIND_NODE = 2'd2;

  typedef struct packed {
    logic [2:0]         command;
    logic [31:0]        handle;
    logic signed [15:0] mark_value;
    logic [6:0]         position;
  } tms_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         top_kind;
    logic [31:0]        top_handle;
    logic signed [15:0] top_mark;
    logic [6:0]         depth;
    logic signed [15:0] mark_out;
    logic [6:0]         found_index;
  } tms_out_t;

  // write enables from the sequencer to the entry store
  typedef struct packed {
    logic kh_we;
    logic mk_we;
  } tms_wr_ctl_t;

endpackage

`default_nettype wire

// ===== sv/tms_store.sv =====
// Entry store of the tagged mark stack: a kind/handle memory and a mark
// memory, each one write port and one registered read port.
// Depends on tms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tms_store
  import tms_pkg::*;
#(
  parameter int STACK_DEPTH  = 64,
  parameter int HANDLE_WIDTH = 32,
  parameter int MARK_WIDTH   = 16,
  localparam int AW = $clog2(STACK_DEPTH)
) (
  input  logic                    clk,
  input  tms_wr_ctl_t             wr_ctl,
  input  logic [AW-1:0]           wr_addr,
  input  logic                    wr_kind,
  input  logic [HANDLE_WIDTH-1:0] wr_handle,
  input  logic [MARK_WIDTH-1:0]   wr_mark,
  input  logic [AW-1:0]           kh_raddr,
  input  logic [AW-1:0]           mk_raddr,
  output logic                    rd_kind,
  output logic [HANDLE_WIDTH-1:0] rd_handle,
  output logic [MARK_WIDTH-1:0]   rd_mark
);

  logic [HANDLE_WIDTH:0]   kh_mem [STACK_DEPTH];
  logic [MARK_WIDTH-1:0]   mk_mem [STACK_DEPTH];
  logic [HANDLE_WIDTH:0]   kh_rd_r;
  logic [MARK_WIDTH-1:0]   mk_rd_r;

  always_ff @(posedge clk) begin
    if (wr_ctl.kh_we) begin
      kh_mem[wr_addr] <= {wr_kind, wr_handle};
    end
    kh_rd_r <= kh_mem[kh_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_ctl.mk_we) begin
      mk_mem[wr_addr] <= wr_mark;
    end
    mk_rd_r <= mk_mem[mk_raddr];
  end

  assign rd_kind   = kh_rd_r[HANDLE_WIDTH];
  assign rd_handle = kh_rd_r[HANDLE_WIDTH-1:0];
  assign rd_mark   = mk_rd_r;

endmodule

`default_nettype wire

// ===== sv/tms_ctrl.sv =====
// Command sequencer of the tagged mark stack: decodes a command, updates
// the stack count, drives the entry store, scans marks, builds the result.
// Depends on tms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tms_ctrl
  import tms_pkg::*;
#(
  parameter int STACK_DEPTH  = 64,
  parameter int HANDLE_WIDTH = 32,
  parameter int MARK_WIDTH   = 16,
  localparam int AW   = $clog2(STACK_DEPTH),
  localparam int CW   = $clog2(STACK_DEPTH + 1),
  localparam int CMPW = (CW > 7) ? CW : 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  tms_in_t                 in_data,
  output logic                    out_valid,
  output tms_out_t                out_data,
  output tms_wr_ctl_t             wr_ctl,
  output logic [AW-1:0]           wr_addr,
  output logic                    wr_kind,
  output logic [HANDLE_WIDTH-1:0] wr_handle,
  output logic [MARK_WIDTH-1:0]   wr_mark,
  output logic [AW-1:0]           kh_raddr,
  output logic [AW-1:0]           mk_raddr,
  input  logic                    rd_kind,
  input  logic [HANDLE_WIDTH-1:0] rd_handle,
  input  logic [MARK_WIDTH-1:0]   rd_mark
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_TOP  = 5'b01000,
    ST_LOAD = 5'b10000
  } tms_state_t;

  tms_state_t              state_r, state_nxt;
  logic [2:0]              cmd_r, cmd_nxt;
  logic [HANDLE_WIDTH-1:0] handle_r, handle_nxt;
  logic [MARK_WIDTH-1:0]   mv_r, mv_nxt;
  logic [6:0]              pos_r, pos_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic [1:0]              status_r, status_nxt;
  logic [MARK_WIDTH-1:0]   mark_out_r, mark_out_nxt;
  tms_out_t                out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic [CW-1:0]   cnt_m1;
  logic [CW-1:0]   idx_m2;
  logic [CMPW-1:0] pos_m1;
  logic [AW-1:0]   top_addr;
  logic            pos_ok;
  logic            full;
  logic            empty;

  assign cnt_m1   = count_r - CW'(1);
  assign idx_m2   = idx_r - CW'(2);
  assign pos_m1   = CMPW'(pos_r) - CMPW'(1);
  assign top_addr = cnt_m1[AW-1:0];
  assign pos_ok   = (pos_r != 7'd0) && (CMPW'(pos_r) <= CMPW'(count_r));
  assign full     = (count_r == CW'(STACK_DEPTH));
  assign empty    = (count_r == '0);

  assign kh_raddr = top_addr;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    handle_nxt    = handle_r;
    mv_nxt        = mv_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    status_nxt    = status_r;
    mark_out_nxt  = mark_out_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    wr_ctl        = '0;
    wr_addr       = count_r[AW-1:0];
    wr_kind       = (cmd_r == CMD_PUSH_NODE);
    wr_handle     = handle_r;
    wr_mark       = mv_r;
    mk_raddr      = top_addr;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt      = in_data.command;
          handle_nxt   = HANDLE_WIDTH'(in_data.handle);
          mv_nxt       = MARK_WIDTH'($signed(in_data.mark_value));
          pos_nxt      = in_data.position;
          status_nxt   = STS_OK;
          mark_out_nxt = '0;
          idx_nxt      = '0;
          state_nxt    = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_nxt = ST_TOP;
        case (cmd_r)
          CMD_PUSH_ELEM, CMD_PUSH_NODE: begin
            if (full) begin
              status_nxt = STS_FULL;
            end else begin
              wr_ctl.kh_we = 1'b1;
              wr_ctl.mk_we = 1'b1;
              wr_mark      = '0;
              count_nxt    = count_r + CW'(1);
            end
          end
          CMD_POP: begin
            if (empty) begin
              status_nxt = STS_EMPTY;
            end else begin
              count_nxt = cnt_m1;
            end
          end
          CMD_SET_TOP: begin
            if (empty) begin
              status_nxt = STS_EMPTY;
            end else begin
              wr_ctl.mk_we = 1'b1;
              wr_addr      = top_addr;
            end
          end
          CMD_READ: begin
            if (!pos_ok) begin
              status_nxt = STS_RANGE;
            end else begin
              mk_raddr = pos_m1[AW-1:0];
            end
          end
          CMD_WRITE: begin
            if (!pos_ok) begin
              status_nxt = STS_RANGE;
            end else begin
              wr_ctl.mk_we = 1'b1;
              wr_addr      = pos_m1[AW-1:0];
            end
          end
          CMD_FIND: begin
            // walk down from the top, one mark read per cycle
            if (!empty) begin
              idx_nxt   = count_r;
              state_nxt = ST_SCAN;
            end
          end
          default: begin
          end
        endcase
      end

      ST_SCAN: begin
        // rd_mark holds the mark of entry idx_r (1-based)
        if (rd_mark == mv_r) begin
          state_nxt = ST_TOP;
        end else if (idx_r == CW'(1)) begin
          idx_nxt   = '0;
          state_nxt = ST_TOP;
        end else begin
          mk_raddr = idx_m2[AW-1:0];
          idx_nxt  = idx_r - CW'(1);
        end
      end

      ST_TOP: begin
        // top read goes out now; a mark read issued last cycle lands here
        if ((cmd_r == CMD_READ) && (status_r == STS_OK)) begin
          mark_out_nxt = rd_mark;
        end
        state_nxt = ST_LOAD;
      end

      ST_LOAD: begin
        out_nxt.status      = status_r;
        out_nxt.depth       = 7'(count_r);
        out_nxt.mark_out    = 16'(mark_out_r);
        out_nxt.found_index = 7'(idx_r);
        if (empty) begin
          out_nxt.top_kind   = KIND_NONE;
          out_nxt.top_handle = '0;
          out_nxt.top_mark   = '0;
        end else begin
          out_nxt.top_kind   = rd_kind ? KIND_NODE : KIND_ELEM;
          out_nxt.top_handle = 32'(rd_handle);
          out_nxt.top_mark   = 16'(rd_mark);
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    handle_r   <= handle_nxt;
    mv_r       <= mv_nxt;
    pos_r      <= pos_nxt;
    idx_r      <= idx_nxt;
    status_r   <= status_nxt;
    mark_out_r <= mark_out_nxt;
    out_r      <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== sv/tagged_mark_stack.sv =====
// Tagged mark stack, top level: command sequencer plus entry store.
// Every command gives one result word, strobed by out_valid for one cycle
// with no way to hold it off, so the receiver must take it when it shows.
// Push, pop, set top mark, mark read/write and query pass the exec, top
// and load states from accept to next accept, the result strobe falling
// in the cycle where busy is low again. Find adds a scan of the entries
// (up to the depth) from the top down through the single mark read port.
// Depends on tms_pkg, tms_ctrl, tms_store.
`timescale 1ns / 1ps
`default_nettype none

module tagged_mark_stack
  import tms_pkg::*;
#(
  parameter int STACK_DEPTH  = 64,
  parameter int HANDLE_WIDTH = 32,
  parameter int MARK_WIDTH   = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  tms_in_t  in_data,
  output logic     out_valid,
  output tms_out_t out_data
);

  localparam int AW = $clog2(STACK_DEPTH);

  tms_wr_ctl_t             wr_ctl;
  logic [AW-1:0]           wr_addr;
  logic                    wr_kind;
  logic [HANDLE_WIDTH-1:0] wr_handle;
  logic [MARK_WIDTH-1:0]   wr_mark;
  logic [AW-1:0]           kh_raddr;
  logic [AW-1:0]           mk_raddr;
  logic                    rd_kind;
  logic [HANDLE_WIDTH-1:0] rd_handle;
  logic [MARK_WIDTH-1:0]   rd_mark;

  tms_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .HANDLE_WIDTH(HANDLE_WIDTH),
    .MARK_WIDTH  (MARK_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .wr_ctl   (wr_ctl),
    .wr_addr  (wr_addr),
    .wr_kind  (wr_kind),
    .wr_handle(wr_handle),
    .wr_mark  (wr_mark),
    .kh_raddr (kh_raddr),
    .mk_raddr (mk_raddr),
    .rd_kind  (rd_kind),
    .rd_handle(rd_handle),
    .rd_mark  (rd_mark)
  );

  tms_store #(
    .STACK_DEPTH (STACK_DEPTH),
    .HANDLE_WIDTH(HANDLE_WIDTH),
    .MARK_WIDTH  (MARK_WIDTH)
  ) u_store (
    .clk      (clk),
    .wr_ctl   (wr_ctl),
    .wr_addr  (wr_addr),
    .wr_kind  (wr_kind),
    .wr_handle(wr_handle),
    .wr_mark  (wr_mark),
    .kh_raddr (kh_raddr),
    .mk_raddr (mk_raddr),
    .rd_kind  (rd_kind),
    .rd_handle(rd_handle),
    .rd_mark  (rd_mark)
  );

endmodule

`default_nettype wire

// ===== sv/tms_checker.sv =====
// Port-level checks for the tagged mark stack, bound to the top level.
// Depends on tms_pkg and tagged_mark_stack.
`timescale 1ns / 1ps
`default_nettype none

module tms_checker
  import tms_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input tms_in_t  in_data,
  input logic     out_valid,
  input tms_out_t out_data
);

  // a word is strobed for one cycle only
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // the result shows while the block is ready again
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while busy");

  // every command but find strobes its result once exec, top and load have passed
  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.command != CMD_FIND)) |-> ##4 out_valid)
    else $error("result missing four cycles after accept");

  // empty stack reports a blank top
  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.depth == 7'd0)) |->
      ((out_data.top_kind == KIND_NONE) && (out_data.top_handle == 32'd0)
       && (out_data.top_mark == 16'sd0)))
    else $error("empty stack reports a top entry");

endmodule

bind tagged_mark_stack tms_checker u_tms_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_data (out_data)
);

`default_nettype wire
